// ----- design/q_measure_accumulator_unit_defines.svh -----
// Assertion macros used by the checker of the Q-measure accumulator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef Q_MEASURE_ACCUMULATOR_UNIT_DEFINES_SVH
`define Q_MEASURE_ACCUMULATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMA_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QMA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/qma_pkg.sv -----
// Package of the Q-measure accumulator: widths, limits, state and register codes.
// Used by the top level and by its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qma_pkg;

  localparam int unsigned LevelCountDefault   = 4;
  localparam int unsigned FractionBitsDefault = 16;

  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned RATIO_W     = 40;
  localparam int unsigned SCORE_W     = 17;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic signed [SUM_W-1:0]   SumMax   = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0]   SumMin   = 32'sh8000_0000;
  localparam logic signed [RATIO_W-1:0] RatioMax = 40'sh7F_FFFF_FFFF;
  localparam logic [SCORE_W-1:0]        ScoreMax = 17'h1_0000;

  typedef enum logic [3:0] {
    QMA_IDLE,
    QMA_ADVANCE,
    QMA_RELEVANT,
    QMA_PREPARE,
    QMA_DIVIDE,
    QMA_ACCUMULATE,
    QMA_FINISH,
    QMA_SCALE,
    QMA_EMIT
  } qma_state_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD,
    CFG_GAIN_ONE,
    CFG_GAIN_TWO,
    CFG_GAIN_THREE,
    CFG_JUDGED_ONE,
    CFG_JUDGED_TWO,
    CFG_JUDGED_THREE,
    CFG_RELEVANT_TOTAL
  } qma_cfg_e;

endpackage

`default_nettype wire

// ----- design/q_measure_accumulator_unit.sv -----
// Q-measure accumulator top level: configuration registers, sequencer and a shared
// restoring divider. Depends on qma_pkg.
//
// Usage: relevance levels of retrieved documents arrive in rank order on the input
// channel (in_valid_i, in_stall_o); a transaction is accepted when valid is high and
// stall is low. The block takes one document at a time and stalls its input until the
// document is fully processed. The document flagged end_of_list produces one result
// transaction (q_score_o, divide_fault_o) on the output channel (out_valid_o,
// out_stall_i) and clears the per-query state.
// Per document the sequencer accepts it, advances the ideal list and runs the
// relevance and finish steps; a relevant document with a positive denominator
// runs the ratio division in between; for the last document the final division may
// follow, and the output is loaded. Both divisions share the radix-2 divider, which
// retires one quotient bit a cycle. Reset loads the register defaults and clears
// the query state; the output is empty. A stalled result holds in the output
// register while the next document is accepted; the next result waits until that
// register is taken. Configuration is written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write it only while idle, not enforced by the block.
`timescale 1ns / 1ps
`default_nettype none

module q_measure_accumulator_unit
  import qma_pkg::*;
#(
  parameter int unsigned LEVEL_COUNT   = LevelCountDefault,
  parameter int unsigned FRACTION_BITS = FractionBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [LEVEL_W-1:0]     doc_level_i,
  input  wire logic                   end_of_list_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [SCORE_W-1:0]     q_score_o,
  output logic                        divide_fault_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int TopInt = (int'(LEVEL_COUNT) - 1 > 3) ? 3 :
                          ((int'(LEVEL_COUNT) - 1 < 1) ? 1 : int'(LEVEL_COUNT) - 1);
  localparam logic [LEVEL_W-1:0] TopLevel = LEVEL_W'(TopInt);
  localparam int OpWidth    = int'(SUM_W) + 1;
  localparam int DivWidth   = OpWidth + int'(FRACTION_BITS);
  localparam int CntWidth   = $clog2(DivWidth + 1);
  localparam int ScaleWidth = RATIO_W + 8;
  localparam int ShiftRight = (FRACTION_BITS >= 16) ? int'(FRACTION_BITS) - 16 : 0;
  localparam int ShiftLeft  = (FRACTION_BITS < 16) ? 16 - int'(FRACTION_BITS) : 0;

  function automatic logic [COUNT_W-1:0] judged_sel(input logic [LEVEL_W-1:0] lvl,
                                                    input logic [COUNT_W-1:0] j1,
                                                    input logic [COUNT_W-1:0] j2,
                                                    input logic [COUNT_W-1:0] j3);
    logic [COUNT_W-1:0] r;
    unique case (lvl)
      2'd1:    r = j1;
      2'd2:    r = j2;
      2'd3:    r = j3;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [GAIN_W-1:0] gain_sel(input logic [LEVEL_W-1:0] lvl,
                                                        input logic signed [GAIN_W-1:0] g1,
                                                        input logic signed [GAIN_W-1:0] g2,
                                                        input logic signed [GAIN_W-1:0] g3);
    logic signed [GAIN_W-1:0] r;
    unique case (lvl)
      2'd1:    r = g1;
      2'd2:    r = g2;
      2'd3:    r = g3;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [GAIN_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SumMin : SumMax;
    end
    return s[SUM_W-1:0];
  endfunction

  // Configuration registers.
  logic        [LEVEL_W-1:0] thresh_q;
  logic signed [GAIN_W-1:0]  gain1_q, gain2_q, gain3_q;
  logic        [COUNT_W-1:0] judged1_q, judged2_q, judged3_q, rel_total_q;

  // Query state.
  qma_state_e                state_q, state_d;
  logic        [COUNT_W-1:0] rank_q, rank_d, seen_q, seen_d, ileft_q, ileft_d;
  logic signed [SUM_W-1:0]   gsum_q, gsum_d, igsum_q, igsum_d;
  logic        [LEVEL_W-1:0] ilevel_q, ilevel_d, lvl_q, lvl_d;
  logic signed [RATIO_W-1:0] rsum_q, rsum_d;
  logic                      fault_q, fault_d, last_q, last_d;
  logic                      out_valid_q, out_valid_d;

  // Divider and result datapath.
  logic [DivWidth-1:0]  dvd_q, dvd_d;
  logic [OpWidth-1:0]   dvs_q, dvs_d, rem_q, rem_d;
  logic [RATIO_W-1:0]   quo_q, quo_d;
  logic                 qovf_q, qovf_d, neg_q, neg_d, final_op_q, final_op_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [SCORE_W-1:0]   res_score_q, res_score_d, score_q, score_d;
  logic                 res_fault_q, res_fault_d, ofault_q, ofault_d;

  logic signed [SUM_W+1:0]   num_s, den_s;
  logic        [SUM_W+1:0]   mag_w;
  logic        [OpWidth:0]   trial, diff;
  logic                      trial_ge;
  logic        [RATIO_W-1:0] ratio_mag;
  logic signed [RATIO_W:0]   ratio_s, acc_s;
  logic        [ScaleWidth-1:0] scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= 2'd1;
      gain1_q     <= 16'sd256;
      gain2_q     <= 16'sd512;
      gain3_q     <= 16'sd768;
      judged1_q   <= '0;
      judged2_q   <= '0;
      judged3_q   <= '0;
      rel_total_q <= '0;
    end else if (cfg_we_i) begin
      unique case (qma_cfg_e'(cfg_index_i))
        CFG_THRESHOLD:      thresh_q    <= cfg_data_i[LEVEL_W-1:0];
        CFG_GAIN_ONE:       gain1_q     <= signed'(cfg_data_i);
        CFG_GAIN_TWO:       gain2_q     <= signed'(cfg_data_i);
        CFG_GAIN_THREE:     gain3_q     <= signed'(cfg_data_i);
        CFG_JUDGED_ONE:     judged1_q   <= cfg_data_i;
        CFG_JUDGED_TWO:     judged2_q   <= cfg_data_i;
        CFG_JUDGED_THREE:   judged3_q   <= cfg_data_i;
        CFG_RELEVANT_TOTAL: rel_total_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= QMA_IDLE;
      rank_q      <= '0;
      seen_q      <= '0;
      ileft_q     <= '0;
      gsum_q      <= '0;
      igsum_q     <= '0;
      ilevel_q    <= 2'd3;
      rsum_q      <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rank_q      <= rank_d;
      seen_q      <= seen_d;
      ileft_q     <= ileft_d;
      gsum_q      <= gsum_d;
      igsum_q     <= igsum_d;
      ilevel_q    <= ilevel_d;
      rsum_q      <= rsum_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q       <= lvl_d;
    last_q      <= last_d;
    dvd_q       <= dvd_d;
    dvs_q       <= dvs_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    qovf_q      <= qovf_d;
    neg_q       <= neg_d;
    final_op_q  <= final_op_d;
    cnt_q       <= cnt_d;
    res_score_q <= res_score_d;
    res_fault_q <= res_fault_d;
    score_q     <= score_d;
    ofault_q    <= ofault_d;
  end

  always_comb begin
    num_s = (SUM_W+2)'(gsum_q) + signed'({10'b0, seen_q, 8'h00});
    den_s = (SUM_W+2)'(igsum_q) + signed'({10'b0, rank_q, 8'h00});
    mag_w = num_s[SUM_W+1] ? unsigned'(-num_s) : unsigned'(num_s);

    trial    = {rem_q, dvd_q[DivWidth-1]};
    diff     = trial - {1'b0, dvs_q};
    trial_ge = (trial >= {1'b0, dvs_q});

    ratio_mag = (qovf_q || quo_q[RATIO_W-1]) ? unsigned'(RatioMax) : quo_q;
    ratio_s   = neg_q ? -signed'({1'b0, ratio_mag}) : signed'({1'b0, ratio_mag});
    acc_s     = (RATIO_W+1)'(rsum_q) + ratio_s;

    scaled = (ScaleWidth'(quo_q) >> ShiftRight) << ShiftLeft;
  end

  always_comb begin
    state_d     = state_q;
    rank_d      = rank_q;
    seen_d      = seen_q;
    ileft_d     = ileft_q;
    gsum_d      = gsum_q;
    igsum_d     = igsum_q;
    ilevel_d    = ilevel_q;
    rsum_d      = rsum_q;
    fault_d     = fault_q;
    lvl_d       = lvl_q;
    last_d      = last_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    qovf_d      = qovf_q;
    neg_d       = neg_q;
    final_op_d  = final_op_q;
    cnt_d       = cnt_q;
    res_score_d = res_score_q;
    res_fault_d = res_fault_q;
    score_d     = score_q;
    ofault_d    = ofault_q;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      QMA_IDLE: begin
        if (in_valid_i) begin
          lvl_d  = (doc_level_i > TopLevel) ? TopLevel : doc_level_i;
          last_d = end_of_list_i;
          if (rank_q == '0) begin
            ilevel_d = TopLevel;
            ileft_d  = judged_sel(TopLevel, judged1_q, judged2_q, judged3_q);
          end
          if (rank_q != '1) begin
            rank_d = rank_q + 1'b1;
          end
          state_d = QMA_ADVANCE;
        end
      end
      QMA_ADVANCE: begin
        if (ileft_q == '0 && ilevel_q != '0) begin
          ilevel_d = ilevel_q - 1'b1;
          ileft_d  = judged_sel(ilevel_q - 1'b1, judged1_q, judged2_q, judged3_q);
        end else begin
          if (ilevel_q != '0 && ileft_q != '0) begin
            ileft_d = ileft_q - 1'b1;
            igsum_d = sat_add(igsum_q, gain_sel(ilevel_q, gain1_q, gain2_q, gain3_q));
          end
          state_d = QMA_RELEVANT;
        end
      end
      QMA_RELEVANT: begin
        if (lvl_q >= thresh_q) begin
          if (seen_q != '1) begin
            seen_d = seen_q + 1'b1;
          end
          gsum_d  = sat_add(gsum_q, gain_sel(lvl_q, gain1_q, gain2_q, gain3_q));
          state_d = QMA_PREPARE;
        end else begin
          state_d = QMA_FINISH;
        end
      end
      QMA_PREPARE: begin
        if (den_s[SUM_W+1] || den_s == '0) begin
          fault_d = 1'b1;
          state_d = QMA_FINISH;
        end else begin
          dvd_d      = {mag_w[OpWidth-1:0], {FRACTION_BITS{1'b0}}};
          dvs_d      = den_s[OpWidth-1:0];
          neg_d      = num_s[SUM_W+1];
          final_op_d = 1'b0;
          rem_d      = '0;
          quo_d      = '0;
          qovf_d     = 1'b0;
          cnt_d      = CntWidth'(DivWidth);
          state_d    = QMA_DIVIDE;
        end
      end
      QMA_DIVIDE: begin
        rem_d  = trial_ge ? diff[OpWidth-1:0] : trial[OpWidth-1:0];
        quo_d  = {quo_q[RATIO_W-2:0], trial_ge};
        qovf_d = qovf_q | quo_q[RATIO_W-1];
        dvd_d  = dvd_q << 1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          state_d = final_op_q ? QMA_SCALE : QMA_ACCUMULATE;
        end
      end
      QMA_ACCUMULATE: begin
        if (acc_s > (RATIO_W+1)'(RatioMax)) begin
          rsum_d = RatioMax;
        end else if (acc_s < -(RATIO_W+1)'(RatioMax)) begin
          rsum_d = -RatioMax;
        end else begin
          rsum_d = acc_s[RATIO_W-1:0];
        end
        state_d = QMA_FINISH;
      end
      QMA_FINISH: begin
        priority if (!last_q) begin
          state_d = QMA_IDLE;
        end else if (rel_total_q == '0) begin
          res_score_d = '0;
          res_fault_d = 1'b1;
          state_d     = QMA_EMIT;
        end else if (!rsum_q[RATIO_W-1] && rsum_q != '0) begin
          dvd_d      = DivWidth'(rsum_q[RATIO_W-2:0]);
          dvs_d      = OpWidth'(rel_total_q);
          final_op_d = 1'b1;
          rem_d      = '0;
          quo_d      = '0;
          qovf_d     = 1'b0;
          cnt_d      = CntWidth'(DivWidth);
          state_d    = QMA_DIVIDE;
        end else begin
          res_score_d = '0;
          res_fault_d = fault_q;
          state_d     = QMA_EMIT;
        end
      end
      QMA_SCALE: begin
        res_score_d = (scaled > ScaleWidth'(ScoreMax)) ? ScoreMax : scaled[SCORE_W-1:0];
        res_fault_d = fault_q;
        state_d     = QMA_EMIT;
      end
      QMA_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          score_d     = res_score_q;
          ofault_d    = res_fault_q;
          out_valid_d = 1'b1;
          rank_d      = '0;
          seen_d      = '0;
          gsum_d      = '0;
          igsum_d     = '0;
          ilevel_d    = 2'd3;
          ileft_d     = '0;
          rsum_d      = '0;
          fault_d     = 1'b0;
          state_d     = QMA_IDLE;
        end
      end
      default: begin
        state_d = QMA_IDLE;
      end
    endcase
  end

  assign in_stall_o     = (state_q != QMA_IDLE);
  assign out_valid_o    = out_valid_q;
  assign q_score_o      = score_q;
  assign divide_fault_o = ofault_q;

endmodule

`default_nettype wire

// ----- design/qma_checker.sv -----
// Port-level checker for the Q-measure accumulator, bound to the top level.
// Depends on qma_pkg and the assertion macros in q_measure_accumulator_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "q_measure_accumulator_unit_defines.svh"

module qma_checker
  import qma_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [SCORE_W-1:0] q_score_o,
  input wire logic               divide_fault_o
);

  `QMA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(q_score_o) && $stable(divide_fault_o), "stalled result transaction changed")
  `QMA_ASSERT_SAME(a_score_range, clk_i, rst_ni, out_valid_o, q_score_o <= ScoreMax, "score above one")
  `QMA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after a transaction")
  `QMA_ASSERT_SAME(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without processing")

endmodule

bind q_measure_accumulator_unit qma_checker u_qma_checker (.*);

`default_nettype wire
